// ----- rtl/acsg_pkg.sv -----
// Shared types, sizes and codes for the ARP cache with spoof guard.
// No dependencies; the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none
package acsg_pkg;

  localparam int CACHE_DEPTH = 64;
  localparam int PEND_DEPTH  = 8;
  localparam int CACHE_AW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CACHE_CW    = $clog2(CACHE_DEPTH + 1);
  localparam int PEND_AW     = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int PEND_CW     = $clog2(PEND_DEPTH + 1);

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;
  localparam int TIMER_W = 24;
  localparam int TRY_W   = 4;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ARP     = 2'd0;
  localparam action_t ACT_RESOLVE = 2'd1;
  localparam action_t ACT_LOOKUP  = 2'd2;
  localparam action_t ACT_TICK    = 2'd3;

  typedef logic [3:0] rc_t;
  localparam rc_t RC_IGNORED     = 4'd0;
  localparam rc_t RC_REPLY       = 4'd1;
  localparam rc_t RC_LEARNED     = 4'd2;
  localparam rc_t RC_SPOOF       = 4'd3;
  localparam rc_t RC_UNSOLICITED = 4'd4;
  localparam rc_t RC_FULL        = 4'd5;
  localparam rc_t RC_REQUEST     = 4'd6;
  localparam rc_t RC_PENDING     = 4'd7;
  localparam rc_t RC_GAVEUP      = 4'd8;
  localparam rc_t RC_LOOKUP      = 4'd9;
  localparam rc_t RC_TICK        = 4'd10;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OWN_IP       = 3'd0;
  localparam cfg_idx_t CFG_IDLE_LIMIT   = 3'd1;
  localparam cfg_idx_t CFG_SWEEP_PERIOD = 3'd2;
  localparam cfg_idx_t CFG_RETRY_WAIT   = 3'd3;
  localparam cfg_idx_t CFG_RETRY_LIMIT  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PEND,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- rtl/acsg_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the cache entries of the ARP cache.
`timescale 1ns / 1ps
`default_nettype none
module acsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/arp_cache_spoof_guard.sv -----
// A lookup or a packet for own_ip reads the cache RAM one entry per cycle, and its result is
// registered after the scan; resolves, ignored and unsolicited packets skip the scan. A tick
// scans the cache, then walks the pending table with one result per retry or give-up and a
// final tick result; a stalled output holds the block. One request at a time; the next is
// taken once the last result is registered. Reset clears all valid bits at once in flip-flops;
// there is no clearing pass. Top level; uses acsg_pkg and acsg_ram.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_spoof_guard (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              action,
  input  wire logic [31:0]             tgt_ip,
  input  wire logic [31:0]             src_ip,
  input  wire logic [47:0]             src_mac,
  input  wire logic                    is_request,
  input  wire logic [31:0]             query_ip,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [3:0]                   result_code,
  output logic [31:0]                  out_ip,
  output logic [47:0]                  out_mac,
  output logic                         hit,
  output logic                         last_of_run,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [31:0]             cfg_data
);
  import acsg_pkg::*;

  // Configuration registers.
  logic [IP_W-1:0]    own_ip;
  logic [TIMER_W-1:0] idle_limit, sweep_period, retry_wait;
  logic [TRY_W-1:0]   retry_limit;

  // Control and latched request.
  state_t             state, state_next;
  action_t            op;
  logic               op_req;
  logic [IP_W-1:0]    key_ip;
  logic [MAC_W-1:0]   op_mac;
  logic [PEND_AW-1:0] pslot;

  // Cache state.
  logic [CACHE_DEPTH-1:0] entry_valid;
  logic [CACHE_CW-1:0]    entry_count;
  logic [STAMP_W-1:0]     time_now;
  logic [TIMER_W-1:0]     sweep_countdown;
  logic                   sweep_now;

  // Pending table.
  logic               pend_valid [PEND_DEPTH];
  logic [IP_W-1:0]    pend_ip    [PEND_DEPTH];
  logic [TIMER_W-1:0] pend_timer [PEND_DEPTH];
  logic [TRY_W-1:0]   pend_tries [PEND_DEPTH];
  logic               cached     [PEND_DEPTH];
  logic [PEND_CW-1:0] pidx;

  // Scan pipeline.
  logic [CACHE_CW-1:0] scan_idx;
  logic                chk_vld;
  logic [CACHE_AW-1:0] chk_idx;
  entry_t              rd_entry;
  logic                found, free_vld;
  logic [CACHE_AW-1:0] found_idx, free_idx;
  logic [MAC_W-1:0]    found_mac;

  // Pending result.
  rc_t              res_code;
  logic [IP_W-1:0]  res_ip;
  logic [MAC_W-1:0] res_mac;
  logic             res_hit, res_last;
  state_t           res_ret;

  // Combinational control.
  logic               accept;
  logic [IP_W-1:0]    in_key;
  logic               in_pend_hit, in_pend_free;
  logic [PEND_AW-1:0] in_pend_idx, in_free_idx;
  logic [TIMER_W-1:0] wait_ticks;
  logic               chk_live, chk_hit, chk_end, scan_issue;
  logic               is_spoof, learn_ok, ram_we;
  logic [CACHE_AW-1:0] ram_waddr;
  entry_t             ram_wdata;
  logic [PEND_AW-1:0] pslot_cur;
  logic               pend_done, pend_expire;
  logic               resp_load;
  rc_t                resp_code;
  logic [IP_W-1:0]    resp_ip;
  logic [MAC_W-1:0]   resp_mac;
  logic               resp_hit, resp_last;
  state_t             resp_ret;
  logic               out_free;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign wait_ticks = (retry_wait == '0) ? TIMER_W'(1) : retry_wait;

  acsg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_DEPTH),
    .AW    (CACHE_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[CACHE_AW-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip       <= '0;
      idle_limit   <= TIMER_W'(300);
      sweep_period <= TIMER_W'(60);
      retry_wait   <= TIMER_W'(1);
      retry_limit  <= TRY_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_IP:       own_ip       <= cfg_data;
        CFG_IDLE_LIMIT:   idle_limit   <= cfg_data[TIMER_W-1:0];
        CFG_SWEEP_PERIOD: sweep_period <= cfg_data[TIMER_W-1:0];
        CFG_RETRY_WAIT:   retry_wait   <= cfg_data[TIMER_W-1:0];
        CFG_RETRY_LIMIT:  retry_limit  <= cfg_data[TRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Parallel search of the small pending table against the incoming address.
  always_comb begin
    in_key       = (action == ACT_ARP) ? src_ip : query_ip;
    in_pend_hit  = 1'b0;
    in_pend_free = 1'b0;
    in_pend_idx  = '0;
    in_free_idx  = '0;
    for (int p = 0; p < PEND_DEPTH; p++) begin
      if (pend_valid[p] && pend_ip[p] == in_key && !in_pend_hit) begin
        in_pend_hit = 1'b1;
        in_pend_idx = PEND_AW'(p);
      end
      if (!pend_valid[p] && !in_pend_free) begin
        in_pend_free = 1'b1;
        in_free_idx  = PEND_AW'(p);
      end
    end
  end

  assign scan_issue = (scan_idx < CACHE_CW'(CACHE_DEPTH));
  assign chk_live   = chk_vld && entry_valid[chk_idx];
  assign chk_hit    = chk_live && rd_entry.ip == key_ip;
  assign chk_end    = chk_vld && chk_idx == CACHE_AW'(CACHE_DEPTH - 1);

  assign is_spoof  = op_req && found && found_mac != op_mac;
  assign learn_ok  = found || entry_count < CACHE_CW'(CACHE_DEPTH);
  assign ram_we    = (state == ST_DECIDE) && op == ACT_ARP && !is_spoof && learn_ok;
  assign ram_waddr = found ? found_idx : free_idx;
  assign ram_wdata = '{ip: key_ip, mac: op_mac, stamp: time_now};

  assign pslot_cur   = pidx[PEND_AW-1:0];
  assign pend_done   = (pidx == PEND_CW'(PEND_DEPTH));
  assign pend_expire = !pend_done && pend_valid[pslot_cur] && !cached[pslot_cur]
                       && pend_timer[pslot_cur] <= TIMER_W'(1);

  always_comb begin
    state_next = state;
    resp_load  = 1'b0;
    resp_code  = RC_IGNORED;
    resp_ip    = '0;
    resp_mac   = '0;
    resp_hit   = 1'b0;
    resp_last  = 1'b1;
    resp_ret   = ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_ARP: begin
              if (tgt_ip != own_ip) begin
                resp_load = 1'b1;
              end else if (!is_request && !in_pend_hit) begin
                resp_load = 1'b1;
                resp_code = RC_UNSOLICITED;
                resp_ip   = src_ip;
                resp_mac  = src_mac;
              end else begin
                state_next = ST_SCAN;
              end
            end
            ACT_RESOLVE: begin
              resp_load = 1'b1;
              resp_ip   = query_ip;
              if (in_pend_hit) begin
                resp_code = RC_PENDING;
              end else if (!in_pend_free) begin
                resp_code = RC_FULL;
              end else begin
                resp_code = RC_REQUEST;
              end
            end
            default: state_next = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (op == ACT_TICK) begin
          if (chk_end) begin
            state_next = ST_PEND;
          end
        end else if (chk_hit || chk_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        resp_load = 1'b1;
        resp_ip   = key_ip;
        if (op == ACT_LOOKUP) begin
          resp_code = RC_LOOKUP;
          resp_mac  = found ? found_mac : '0;
          resp_hit  = found;
        end else begin
          resp_mac = op_mac;
          if (is_spoof) begin
            resp_code = RC_SPOOF;
          end else if (!learn_ok) begin
            resp_code = RC_FULL;
          end else begin
            resp_code = op_req ? RC_REPLY : RC_LEARNED;
          end
        end
      end
      ST_PEND: begin
        if (pend_done) begin
          resp_load = 1'b1;
          resp_code = RC_TICK;
        end else if (pend_expire) begin
          resp_load = 1'b1;
          resp_ip   = pend_ip[pslot_cur];
          resp_last = 1'b0;
          resp_ret  = ST_PEND;
          resp_code = (pend_tries[pslot_cur] >= retry_limit) ? RC_GAVEUP : RC_REQUEST;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = res_ret;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (resp_load) begin
      state_next = ST_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      res_code <= resp_code;
      res_ip   <= resp_ip;
      res_mac  <= resp_mac;
      res_hit  <= resp_hit;
      res_last <= resp_last;
      res_ret  <= resp_ret;
    end
    if (state == ST_RESP && out_free) begin
      result_code <= res_code;
      out_ip      <= res_ip;
      out_mac     <= res_mac;
      hit         <= res_hit;
      last_of_run <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Request latch and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= action;
      op_req   <= is_request;
      key_ip   <= in_key;
      op_mac   <= src_mac;
      pslot    <= in_pend_idx;
      scan_idx <= '0;
      chk_vld  <= 1'b0;
      found    <= 1'b0;
      free_vld <= 1'b0;
      pidx     <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + CACHE_CW'(1);
      chk_vld  <= scan_issue;
      chk_idx  <= scan_idx[CACHE_AW-1:0];
      if (chk_hit) begin
        found     <= 1'b1;
        found_idx <= chk_idx;
        found_mac <= rd_entry.mac;
      end
      if (chk_vld && !entry_valid[chk_idx] && !free_vld) begin
        free_vld <= 1'b1;
        free_idx <= chk_idx;
      end
    end else if (state == ST_PEND && !pend_done) begin
      pidx <= pidx + PEND_CW'(1);
    end
  end

  // Cache valid bits, count, time and sweep countdown.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid     <= '0;
      entry_count     <= '0;
      time_now        <= '0;
      sweep_countdown <= '0;
      sweep_now       <= 1'b0;
    end else begin
      if (accept && action == ACT_TICK) begin
        time_now  <= time_now + STAMP_W'(1);
        sweep_now <= (sweep_countdown == '0);
        if (sweep_countdown == '0) begin
          sweep_countdown <= (sweep_period == '0) ? '0 : sweep_period - TIMER_W'(1);
        end else begin
          sweep_countdown <= sweep_countdown - TIMER_W'(1);
        end
      end
      // Age uses the advanced time; the difference wraps modulo 2^32.
      if (state == ST_SCAN && op == ACT_TICK && sweep_now && chk_live &&
          (time_now - rd_entry.stamp) > STAMP_W'(idle_limit)) begin
        entry_valid[chk_idx] <= 1'b0;
        entry_count          <= entry_count - CACHE_CW'(1);
      end
      if (ram_we && !found) begin
        entry_valid[free_idx] <= 1'b1;
        entry_count           <= entry_count + CACHE_CW'(1);
      end
    end
  end

  // Pending table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PEND_DEPTH; p++) begin
        pend_valid[p] <= 1'b0;
        cached[p]     <= 1'b0;
      end
    end else begin
      if (accept) begin
        for (int p = 0; p < PEND_DEPTH; p++) begin
          cached[p] <= 1'b0;
        end
        if (action == ACT_RESOLVE && !in_pend_hit && in_pend_free) begin
          pend_valid[in_free_idx] <= 1'b1;
          pend_ip[in_free_idx]    <= query_ip;
          pend_timer[in_free_idx] <= wait_ticks;
          pend_tries[in_free_idx] <= TRY_W'(1);
        end
      end
      // A tick's cache scan marks pending addresses that are already cached.
      if (state == ST_SCAN && op == ACT_TICK) begin
        for (int p = 0; p < PEND_DEPTH; p++) begin
          if (chk_live && rd_entry.ip == pend_ip[p]) begin
            cached[p] <= 1'b1;
          end
        end
      end
      if (ram_we && !op_req) begin
        pend_valid[pslot] <= 1'b0;
      end
      if (state == ST_PEND && !pend_done && pend_valid[pslot_cur]) begin
        if (cached[pslot_cur]) begin
          pend_valid[pslot_cur] <= 1'b0;
        end else if (!pend_expire) begin
          pend_timer[pslot_cur] <= pend_timer[pslot_cur] - TIMER_W'(1);
        end else if (pend_tries[pslot_cur] >= retry_limit) begin
          pend_valid[pslot_cur] <= 1'b0;
        end else begin
          pend_tries[pslot_cur] <= pend_tries[pslot_cur] + TRY_W'(1);
          pend_timer[pslot_cur] <= wait_ticks;
        end
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("entry count differs from the number of valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CACHE_CW'(CACHE_DEPTH))
    else $error("entry count exceeds the cache depth");

  a_tick_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_TICK) |=> (state == ST_SCAN))
    else $error("tick did not start a cache scan");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && res_last) |-> (res_ret == ST_IDLE))
    else $error("final result does not return to idle");

endmodule
`default_nettype wire

// ----- tb/tb_arp_cache_spoof_guard.sv -----
// Testbench for arp_cache_spoof_guard: directed table, cache/pending fill and random phases.
// Expected results come from a behavioral model of the cache kept here; uses acsg_pkg only.
`timescale 1ns / 1ps
module tb_arp_cache_spoof_guard;
  import acsg_pkg::*;

  typedef struct {
    rc_t         code;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        hit;
    logic        last;
  } arp_result_t;

  typedef struct {
    action_t     act;
    logic [31:0] tip;
    logic [31:0] sip;
    logic [47:0] smac;
    logic        req;
    logic [31:0] qip;
    bit          typed;
    rc_t         code;
    logic [31:0] eip;
    logic [47:0] emac;
    logic        ehit;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] action = 0;
  logic [31:0] tgt_ip = 0, src_ip = 0, query_ip = 0;
  logic [47:0] src_mac = 0;
  logic is_request = 0;
  logic out_valid, out_ready = 0;
  logic [3:0] result_code;
  logic [31:0] out_ip;
  logic [47:0] out_mac;
  logic hit, last_of_run;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  arp_cache_spoof_guard u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Mirror of the block's configuration and tables.
  logic [31:0] m_own_ip = 0;
  logic [23:0] m_idle = 300, m_sweep = 60, m_retry = 1;
  logic [3:0]  m_maxr = 3;
  logic        c_valid[CACHE_DEPTH];
  logic [31:0] c_ip[CACHE_DEPTH];
  logic [47:0] c_mac[CACHE_DEPTH];
  logic [31:0] c_stamp[CACHE_DEPTH];
  int          c_count = 0;
  logic [31:0] now_ticks = 0;
  logic [23:0] sweep_cd = 0;
  logic        p_valid[PEND_DEPTH];
  logic [31:0] p_ip[PEND_DEPTH];
  logic [23:0] p_timer[PEND_DEPTH];
  logic [3:0]  p_tries[PEND_DEPTH];

  arp_result_t pending_results[$];
  int errors = 0;
  int n_checked = 0;
  int burst_left = 0;
  bit hold_long = 0;
  logic [31:0] ip_pool[12];
  logic [47:0] mac_pool[12][2];

  initial begin
    for (int i = 0; i < CACHE_DEPTH; i++) c_valid[i] = 0;
    for (int i = 0; i < PEND_DEPTH; i++) p_valid[i] = 0;
  end

  function automatic int cache_idx(logic [31:0] ip);
    for (int i = 0; i < CACHE_DEPTH; i++)
      if (c_valid[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int pend_idx(logic [31:0] ip);
    for (int i = 0; i < PEND_DEPTH; i++)
      if (p_valid[i] && p_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic bit learn_entry(logic [31:0] ip, logic [47:0] mac);
    int i;
    i = cache_idx(ip);
    if (i >= 0) begin
      c_mac[i] = mac;
      c_stamp[i] = now_ticks;
      return 1;
    end
    if (c_count >= CACHE_DEPTH) return 0;
    for (int k = 0; k < CACHE_DEPTH; k++) begin
      if (!c_valid[k]) begin
        c_valid[k] = 1;
        c_ip[k] = ip;
        c_mac[k] = mac;
        c_stamp[k] = now_ticks;
        c_count++;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void add_result(rc_t code, logic [31:0] ip, logic [47:0] mac, logic h);
    arp_result_t r;
    r.code = code;
    r.ip = ip;
    r.mac = mac;
    r.hit = h;
    r.last = 0;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_results(stim_row_t s);
    int i, p, f;
    arp_result_t r;
    case (s.act)
      ACT_ARP: begin
        if (s.tip != m_own_ip) add_result(RC_IGNORED, 0, 0, 0);
        else if (s.req) begin
          i = cache_idx(s.sip);
          if (i >= 0 && c_mac[i] != s.smac) add_result(RC_SPOOF, s.sip, s.smac, 0);
          else if (learn_entry(s.sip, s.smac)) add_result(RC_REPLY, s.sip, s.smac, 0);
          else add_result(RC_FULL, s.sip, s.smac, 0);
        end else begin
          p = pend_idx(s.sip);
          if (p < 0) add_result(RC_UNSOLICITED, s.sip, s.smac, 0);
          else if (learn_entry(s.sip, s.smac)) begin
            p_valid[p] = 0;
            add_result(RC_LEARNED, s.sip, s.smac, 0);
          end else add_result(RC_FULL, s.sip, s.smac, 0);
        end
      end
      ACT_RESOLVE: begin
        if (pend_idx(s.qip) >= 0) add_result(RC_PENDING, s.qip, 0, 0);
        else begin
          f = -1;
          for (int k = PEND_DEPTH - 1; k >= 0; k--) if (!p_valid[k]) f = k;
          if (f < 0) add_result(RC_FULL, s.qip, 0, 0);
          else begin
            p_valid[f] = 1;
            p_ip[f] = s.qip;
            p_timer[f] = (m_retry == 0) ? 24'd1 : m_retry;
            p_tries[f] = 1;
            add_result(RC_REQUEST, s.qip, 0, 0);
          end
        end
      end
      ACT_LOOKUP: begin
        i = cache_idx(s.qip);
        if (i >= 0) add_result(RC_LOOKUP, s.qip, c_mac[i], 1);
        else add_result(RC_LOOKUP, s.qip, 0, 0);
      end
      default: begin
        now_ticks = now_ticks + 32'd1;
        for (int k = 0; k < PEND_DEPTH; k++) begin
          if (!p_valid[k]) continue;
          if (cache_idx(p_ip[k]) >= 0) begin
            p_valid[k] = 0;
            continue;
          end
          if (p_timer[k] > 1) begin
            p_timer[k]--;
            continue;
          end
          if (p_tries[k] >= m_maxr) begin
            p_valid[k] = 0;
            add_result(RC_GAVEUP, p_ip[k], 0, 0);
          end else begin
            p_tries[k] = p_tries[k] + 4'd1;
            p_timer[k] = (m_retry == 0) ? 24'd1 : m_retry;
            add_result(RC_REQUEST, p_ip[k], 0, 0);
          end
        end
        if (sweep_cd == 0) begin
          for (int k = 0; k < CACHE_DEPTH; k++) begin
            if (c_valid[k] && (now_ticks - c_stamp[k]) > {8'd0, m_idle}) begin
              c_valid[k] = 0;
              c_count--;
            end
          end
          sweep_cd = (m_sweep == 0) ? 24'd0 : m_sweep - 24'd1;
        end else sweep_cd--;
        add_result(RC_TICK, 0, 0, 0);
      end
    endcase
    r = pending_results.pop_back();
    r.last = 1;
    pending_results.push_back(r);
  endfunction

  task automatic send_request(stim_row_t s);
    int queued;
    arp_result_t r;
    if (burst_left == 0) begin
      @(negedge clk) in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else @(negedge clk);
    burst_left--;
    in_valid <= 1;
    action <= s.act;
    tgt_ip <= s.tip;
    src_ip <= s.sip;
    src_mac <= s.smac;
    is_request <= s.req;
    query_ip <= s.qip;
    do @(posedge clk); while (!in_ready);
    queued = pending_results.size();
    predict_results(s);
    if (s.typed) begin
      // Rows with a hand-written answer replace the computed one.
      while (pending_results.size() > queued) void'(pending_results.pop_back());
      r.code = s.code;
      r.ip = s.eip;
      r.mac = s.emac;
      r.hit = s.ehit;
      r.last = 1;
      pending_results.push_back(r);
    end
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    // Leave some quiet cycles before the registers are rewritten.
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OWN_IP:       m_own_ip = data;
      CFG_IDLE_LIMIT:   m_idle = data[23:0];
      CFG_SWEEP_PERIOD: m_sweep = data[23:0];
      CFG_RETRY_WAIT:   m_retry = data[23:0];
      default:          m_maxr = data[3:0];
    endcase
    @(negedge clk) cfg_valid <= 0;
  endtask

  task automatic configure(logic [31:0] own, logic [23:0] idle, logic [23:0] sw,
                           logic [23:0] rw, logic [3:0] mr);
    write_reg(CFG_OWN_IP, own);
    write_reg(CFG_IDLE_LIMIT, {8'd0, idle});
    write_reg(CFG_SWEEP_PERIOD, {8'd0, sw});
    write_reg(CFG_RETRY_WAIT, {8'd0, rw});
    write_reg(CFG_RETRY_LIMIT, {28'd0, mr});
  endtask

  function automatic stim_row_t mk(action_t a, logic [31:0] tip, logic [31:0] sip,
                                   logic [47:0] mac, logic req, logic [31:0] qip);
    stim_row_t s;
    s.act = a;
    s.tip = tip;
    s.sip = sip;
    s.smac = mac;
    s.req = req;
    s.qip = qip;
    s.typed = 0;
    s.code = RC_IGNORED;
    s.eip = 0;
    s.emac = 0;
    s.ehit = 0;
    return s;
  endfunction

  function automatic stim_row_t mkx(stim_row_t s, rc_t c, logic [31:0] ip,
                                    logic [47:0] mac, logic h);
    s.typed = 1;
    s.code = c;
    s.eip = ip;
    s.emac = mac;
    s.ehit = h;
    return s;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t s;
    int k, sel;
    k = $urandom_range(0, 11);
    s = mk(ACT_ARP, m_own_ip, ip_pool[k], mac_pool[k][$urandom_range(0, 1)],
           1'($urandom_range(0, 1)), ip_pool[$urandom_range(0, 11)]);
    if ($urandom_range(0, 9) == 0) s.sip = $urandom;
    if ($urandom_range(0, 9) == 0) s.smac = 48'({$urandom, $urandom});
    if ($urandom_range(0, 9) == 0) s.qip = $urandom;
    if ($urandom_range(0, 7) == 0) s.tip = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 4) s.act = ACT_ARP;
    else if (sel < 6) s.act = ACT_RESOLVE;
    else if (sel < 8) s.act = ACT_LOOKUP;
    else s.act = ACT_TICK;
    return s;
  endfunction

  // Receiver: alternates between always-ready stretches and a stall pattern.
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_long) begin
      out_ready <= 0;
    end else if ((rx_cycle / 64) % 3 == 0) begin
      out_ready <= 1;
    end else begin
      out_ready <= (rx_cycle % 7 != 3) && (rx_cycle % 13 < 9);
    end
  end

  // Long hold-off, counted in cycles, requested by the stimulus.
  initial begin
    wait (hold_long);
    repeat (400) @(negedge clk);
    hold_long = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      arp_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result code=%0d ip=%h mac=%h", result_code, out_ip, out_mac);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (result_code !== e.code || out_ip !== e.ip || out_mac !== e.mac ||
            hit !== e.hit || last_of_run !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: exp code=%0d ip=%h mac=%h hit=%b last=%b, got %0d %h %h %b %b",
                     e.code, e.ip, e.mac, e.hit, e.last,
                     result_code, out_ip, out_mac, hit, last_of_run);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t tbl[$];
    logic [31:0] ip_a, ip_b, ip_c;
    logic [47:0] mac_a;
    int n_items;
    ip_a = 32'hC0A80001;
    ip_b = 32'hC0A80002;
    ip_c = 32'hC0A80003;
    mac_a = 48'h0200_1111_2222;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 0;

    // Directed part, with the block's reset configuration (own_ip zero).
    tbl.push_back(mkx(mk(ACT_LOOKUP, 0, 0, 0, 0, 0), RC_LOOKUP, 0, 0, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 1, ip_a, mac_a, 1, 0), RC_IGNORED, 0, 0, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, ip_a, mac_a, 1, 0), RC_REPLY, ip_a, mac_a, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, ip_a, ~mac_a, 1, 0), RC_SPOOF, ip_a, ~mac_a, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, ip_a, mac_a, 1, 0), RC_REPLY, ip_a, mac_a, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, ip_b, mac_a, 0, 0), RC_UNSOLICITED, ip_b, mac_a, 0));
    tbl.push_back(mkx(mk(ACT_RESOLVE, 0, 0, 0, 0, ip_b), RC_REQUEST, ip_b, 0, 0));
    tbl.push_back(mkx(mk(ACT_RESOLVE, 0, 0, 0, 0, ip_b), RC_PENDING, ip_b, 0, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, ip_b, 48'h1, 0, 0), RC_LEARNED, ip_b, 48'h1, 0));
    tbl.push_back(mkx(mk(ACT_LOOKUP, 0, 0, 0, 0, ip_a), RC_LOOKUP, ip_a, mac_a, 1));
    tbl.push_back(mkx(mk(ACT_LOOKUP, 0, 0, 0, 0, 32'hFFFFFFFF), RC_LOOKUP, 32'hFFFFFFFF, 0, 0));
    tbl.push_back(mk(ACT_RESOLVE, 0, 0, 0, 0, ip_c));
    tbl.push_back(mk(ACT_RESOLVE, 0, 0, 0, 0, ip_a));
    for (int t = 0; t < 5; t++) tbl.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 1, 0),
                      RC_REPLY, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 0));
    tbl.push_back(mkx(mk(ACT_ARP, 0, 0, 0, 1, 0), RC_REPLY, 0, 0, 0));
    tbl.push_back(mk(ACT_ARP, 0, ip_b, 48'h2, 0, 0));
    tbl.push_back(mk(ACT_LOOKUP, 0, 0, 0, 0, ip_b));
    foreach (tbl[i]) send_request(tbl[i]);
    n_items = tbl.size();

    // Fill the cache past its depth, refresh one entry, then fill the pending table and tick.
    for (int k = 0; k < CACHE_DEPTH + 2; k++) begin
      send_request(mk(ACT_ARP, 0, 32'h0A000000 + k, {16'hA5A5, 32'h0A000000 + k}, 1, 0));
      n_items++;
    end
    send_request(mk(ACT_ARP, 0, 32'h0A000001, {16'hA5A5, 32'h0A000001}, 1, 0));
    for (int k = 0; k <= PEND_DEPTH; k++)
      send_request(mk(ACT_RESOLVE, 0, 0, 0, 0, 32'h0B000000 + k));
    for (int k = 0; k < 3; k++) send_request(mk(ACT_TICK, 0, 0, 0, 0, 0));
    n_items += PEND_DEPTH + 5;
    drain();

    // Random phases, each under a different register setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: configure($urandom, 24'd5, 24'd3, 24'd2, 4'd2);
        1: configure(32'hFFFFFFFF, 24'd0, 24'd1, 24'd1, 4'd1);
        2: configure($urandom, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd15);
        default: configure(32'h0, 24'd20, 24'd4, 24'd3, 4'd15);
      endcase
      for (int k = 0; k < 12; k++) begin
        ip_pool[k] = $urandom;
        mac_pool[k][0] = 48'({$urandom, $urandom});
        mac_pool[k][1] = 48'({$urandom, $urandom});
      end
      for (int k = 0; k < 25; k++) begin
        if (ph == 3 && k == 10) hold_long = 1;
        send_request(random_row());
        n_items++;
      end
      drain();
    end

    $display("Checked %0d results from %0d requests over four register settings,", n_checked,
             n_items);
    $display("including spoofs, full cache and pending table, retries and sweeps.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/acsg_pkg.sv
rtl/acsg_ram.sv
rtl/arp_cache_spoof_guard.sv
tb/tb_arp_cache_spoof_guard.sv
